// ===== hw/rtl/ufs_pkg.sv =====
// ----------------------------------------------------------------------------
// ufs_pkg
// Shared types and constants for the payload frame splitter.
// ----------------------------------------------------------------------------
package ufs_pkg;

  localparam int MAX_PAYLOAD_BYTES = 4096;

  localparam int PLEN_W  = 13;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 24;

  localparam int FALLBACK_HEADER = 12;
  localparam int MIN_HEADER      = 2;

  localparam logic [COUNT_W-1:0] EXPECTED_RESET = 24'd1228800;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};

  // APB register map: one register, word index taken from paddr[2]
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_EXPECTED_IDX = 1'b0;

  typedef enum logic [0:0] {
    ACT_BYTE  = 1'b0,
    ACT_FLUSH = 1'b1
  } action_e;

  typedef enum logic [0:0] {
    KIND_DATA  = 1'b0,
    KIND_CLOSE = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [BYTE_W-1:0]   data;
    logic                ok;
    logic [COUNT_W-1:0]  length;
  } result_t;

endpackage

// ===== hw/rtl/ufs_apb_regs.sv =====
// ----------------------------------------------------------------------------
// ufs_apb_regs
// APB register file holding the expected frame size.
// ----------------------------------------------------------------------------
module ufs_apb_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ufs_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [ufs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [ufs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output logic [ufs_pkg::COUNT_W-1:0]        expected_o
);

  logic [ufs_pkg::COUNT_W-1:0] expected_q, expected_d;
  logic                        hit;

  assign hit    = (paddr[2:2] == ufs_pkg::REG_EXPECTED_IDX);
  assign pready = 1'b1;

  always_comb begin
    expected_d = expected_q;
    if (psel && penable && pwrite && hit) begin
      expected_d = pwdata[ufs_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= ufs_pkg::EXPECTED_RESET;
    end else begin
      expected_q <= expected_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = ufs_pkg::APB_DATA_W'(expected_q);
    end
  end

  assign expected_o = expected_q;

endmodule

// ===== hw/rtl/ufs_core.sv =====
// ----------------------------------------------------------------------------
// ufs_core
// Payload parser: header strip, toggle tracking and frame byte counting.
// ----------------------------------------------------------------------------
module ufs_core #(
  parameter int MaxPayloadBytes = ufs_pkg::MAX_PAYLOAD_BYTES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [0:0]                     action_i,
  input  logic [ufs_pkg::BYTE_W-1:0]     data_byte_i,
  input  logic [ufs_pkg::PLEN_W-1:0]     payload_length_i,
  input  logic [ufs_pkg::COUNT_W-1:0]    expected_i,
  output logic                           res_valid_o,
  output ufs_pkg::result_t               res_o
);

  localparam int LenW = $clog2(MaxPayloadBytes + 1);
  localparam int PosW = $clog2(MaxPayloadBytes);
  localparam int CmpW = (LenW > ufs_pkg::PLEN_W) ? LenW : ufs_pkg::PLEN_W;

  logic [PosW-1:0]             pos_q, pos_d;
  logic [LenW-1:0]             latched_q, latched_d;
  logic [LenW-1:0]             header_q, header_d;
  logic                        seen_q, seen_d;
  logic                        last_q, last_d;
  logic [ufs_pkg::COUNT_W-1:0] count_q, count_d;

  logic [CmpW-1:0] plen_ext, plen_nz, plen_clamp, byte_ext, hdr_sel;
  logic [LenW-1:0] pos_inc, lat_eff;
  logic            hdr_bad;
  logic            toggle;

  always_comb begin
    plen_ext   = CmpW'(payload_length_i);
    plen_nz    = (plen_ext == '0) ? CmpW'(1) : plen_ext;
    plen_clamp = (plen_nz > CmpW'(MaxPayloadBytes)) ? CmpW'(MaxPayloadBytes) : plen_nz;
    byte_ext   = CmpW'(data_byte_i);
    hdr_bad    = (byte_ext < CmpW'(ufs_pkg::MIN_HEADER)) || (byte_ext > plen_clamp);
    if (hdr_bad) begin
      hdr_sel = (plen_clamp >= CmpW'(ufs_pkg::FALLBACK_HEADER)) ?
                CmpW'(ufs_pkg::FALLBACK_HEADER) : plen_clamp;
    end else begin
      hdr_sel = byte_ext;
    end
  end

  assign toggle  = data_byte_i[0];
  assign pos_inc = LenW'(pos_q) + LenW'(1);

  always_comb begin
    pos_d       = pos_q;
    latched_d   = latched_q;
    header_d    = header_q;
    seen_d      = seen_q;
    last_d      = last_q;
    count_d     = count_q;
    lat_eff     = latched_q;
    res_valid_o = 1'b0;
    res_o.kind   = ufs_pkg::KIND_DATA;
    res_o.data   = '0;
    res_o.ok     = 1'b0;
    res_o.length = '0;

    // close result on flush or toggle change; data result for bytes past the header
    if (accept_i) begin
      if (action_i == ufs_pkg::ACT_FLUSH) begin
        if (count_q != '0) begin
          res_valid_o  = 1'b1;
          res_o.kind   = ufs_pkg::KIND_CLOSE;
          res_o.ok     = (count_q == expected_i);
          res_o.length = count_q;
          count_d      = '0;
        end
        pos_d  = '0;
        seen_d = 1'b0;
        last_d = 1'b0;
      end else begin
        if (pos_q == '0) begin
          latched_d = LenW'(plen_clamp);
          header_d  = LenW'(hdr_sel);
          lat_eff   = LenW'(plen_clamp);
        end else if (latched_q >= LenW'(2)) begin
          if (pos_q == PosW'(1)) begin
            if (seen_q && (toggle != last_q) && (count_q != '0)) begin
              res_valid_o  = 1'b1;
              res_o.kind   = ufs_pkg::KIND_CLOSE;
              res_o.ok     = (count_q == expected_i);
              res_o.length = count_q;
              count_d      = '0;
            end
            last_d = toggle;
            seen_d = 1'b1;
          end else if (LenW'(pos_q) >= header_q) begin
            res_valid_o = 1'b1;
            res_o.kind  = ufs_pkg::KIND_DATA;
            res_o.data  = data_byte_i;
            if (count_q != ufs_pkg::COUNT_MAX) begin
              count_d = count_q + ufs_pkg::COUNT_W'(1);
            end
          end
        end
        pos_d = (pos_inc >= lat_eff) ? '0 : PosW'(pos_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      latched_q <= '0;
      header_q  <= '0;
      seen_q    <= 1'b0;
      last_q    <= 1'b0;
      count_q   <= '0;
    end else begin
      pos_q     <= pos_d;
      latched_q <= latched_d;
      header_q  <= header_d;
      seen_q    <= seen_d;
      last_q    <= last_d;
      count_q   <= count_d;
    end
  end

endmodule

// ===== hw/rtl/ufs_out_buf.sv =====
// ----------------------------------------------------------------------------
// ufs_out_buf
// Result register plus skid slot, which takes one result while output stalls.
// ----------------------------------------------------------------------------
module ufs_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ufs_pkg::result_t res_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ufs_pkg::result_t out_o
);

  ufs_pkg::result_t out_q, out_d, skid_q, skid_d;
  logic             ov_q, ov_d, sv_q, sv_d;

  // a push only arrives while the skid slot is empty
  always_comb begin
    out_d  = out_q;
    ov_d   = ov_q;
    skid_d = skid_q;
    sv_d   = sv_q;
    if (ov_q && !out_ready_i) begin
      if (push_i) begin
        skid_d = res_i;
        sv_d   = 1'b1;
      end
    end else if (sv_q) begin
      out_d = skid_q;
      ov_d  = 1'b1;
      sv_d  = 1'b0;
    end else begin
      out_d = res_i;
      ov_d  = push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      sv_q <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign space_o     = !sv_q;
  assign out_valid_o = ov_q;
  assign out_o       = out_q;

endmodule

// ===== hw/rtl/uvc_payload_frame_splitter_top.sv =====
// A result is registered in the output buffer once its beat is accepted.
// Throughput: one beat per cycle while the skid slot is empty; the parser
// state updates on each accepted beat. A two-entry output buffer (result
// register plus skid slot) keeps input ready until the skid slot fills.
// Reset (rst_ni, async low) clears parser state, output valid and sets the
// expected frame size to 1228800.
// ----------------------------------------------------------------------------
// uvc_payload_frame_splitter_top
// Video payload deframer: strips headers, splits frames on toggle changes.
// ----------------------------------------------------------------------------
module uvc_payload_frame_splitter_top #(
  parameter int MaxPayloadBytes = ufs_pkg::MAX_PAYLOAD_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            action_i,
  input  logic [ufs_pkg::BYTE_W-1:0]      data_byte_i,
  input  logic [ufs_pkg::PLEN_W-1:0]      payload_length_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            result_kind_o,
  output logic [ufs_pkg::BYTE_W-1:0]      data_out_o,
  output logic                            frame_ok_o,
  output logic [ufs_pkg::COUNT_W-1:0]     frame_length_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ufs_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ufs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ufs_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic [ufs_pkg::COUNT_W-1:0] expected;
  logic                        accept;
  logic                        res_valid;
  logic                        space;
  ufs_pkg::result_t            res;
  ufs_pkg::result_t            out_res;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = space;

  ufs_apb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .expected_o (expected)
  );

  ufs_core #(
    .MaxPayloadBytes (MaxPayloadBytes)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .action_i         (action_i),
    .data_byte_i      (data_byte_i),
    .payload_length_i (payload_length_i),
    .expected_i       (expected),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  ufs_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_res)
  );

  assign result_kind_o  = out_res.kind;
  assign data_out_o     = out_res.data;
  assign frame_ok_o     = out_res.ok;
  assign frame_length_o = out_res.length;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the payload frame splitter. Drives payload beats
// and flushes through valid/ready with random gaps and output stalls, predicts
// stripped data and frame closes in a scoreboard, and checks them in order.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [ufs_pkg::APB_ADDR_W-1:0] EXPECTED_ADDR =
    {ufs_pkg::REG_EXPECTED_IDX, 2'b00};
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 150;

  // Mirrors the deframer: header strip, toggle tracking, frame byte count.
  class frame_scoreboard;
    ufs_pkg::result_t                     expected_q[$];
    logic [ufs_pkg::COUNT_W-1:0]          good_size;
    logic [11:0]                          pos;
    logic [ufs_pkg::PLEN_W-1:0]           latched_len;
    logic [ufs_pkg::PLEN_W-1:0]           hdr_len;
    bit                                   toggle_seen;
    bit                                   last_toggle;
    logic [ufs_pkg::COUNT_W-1:0]          open_count;
    int                                   fail_count;
    int                                   data_seen;
    int                                   closes_seen;
    int                                   good_closes;

    function new();
      good_size   = ufs_pkg::EXPECTED_RESET;
      pos         = '0;
      latched_len = '0;
      hdr_len     = '0;
      toggle_seen = 1'b0;
      last_toggle = 1'b0;
      open_count  = '0;
      fail_count  = 0;
      data_seen   = 0;
      closes_seen = 0;
      good_closes = 0;
    endfunction

    function void set_good_size(logic [ufs_pkg::COUNT_W-1:0] size);
      good_size = size;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void close_frame();
      ufs_pkg::result_t r;
      if (open_count == '0) return;
      r.kind   = ufs_pkg::KIND_CLOSE;
      r.data   = '0;
      r.ok     = (open_count == good_size);
      r.length = open_count;
      expected_q.insert(expected_q.size(), r);
      open_count = '0;
    endfunction

    function void note_beat(ufs_pkg::action_e act, logic [ufs_pkg::BYTE_W-1:0] b,
                            logic [ufs_pkg::PLEN_W-1:0] plen);
      ufs_pkg::result_t           r;
      logic [ufs_pkg::PLEN_W-1:0] len;
      int                         nxt;
      if (act == ufs_pkg::ACT_FLUSH) begin
        close_frame();
        pos         = '0;
        toggle_seen = 1'b0;
        last_toggle = 1'b0;
        return;
      end
      if (pos == '0) begin
        len = (plen == '0) ? ufs_pkg::PLEN_W'(1) : plen;
        if (len > ufs_pkg::MAX_PAYLOAD_BYTES)
          len = ufs_pkg::PLEN_W'(ufs_pkg::MAX_PAYLOAD_BYTES);
        latched_len = len;
        if (b < ufs_pkg::MIN_HEADER || b > len)
          hdr_len = (len >= ufs_pkg::FALLBACK_HEADER) ?
                    ufs_pkg::PLEN_W'(ufs_pkg::FALLBACK_HEADER) : len;
        else
          hdr_len = ufs_pkg::PLEN_W'(b);
      end else if (latched_len >= 2) begin
        if (pos == 12'd1) begin
          if (toggle_seen && b[0] != last_toggle) close_frame();
          last_toggle = b[0];
          toggle_seen = 1'b1;
        end else if (pos >= hdr_len) begin
          r.kind   = ufs_pkg::KIND_DATA;
          r.data   = b;
          r.ok     = 1'b0;
          r.length = '0;
          expected_q.insert(expected_q.size(), r);
          if (open_count != ufs_pkg::COUNT_MAX) open_count++;
        end
      end
      nxt = pos + 1;
      pos = (nxt >= latched_len) ? '0 : 12'(nxt);
    endfunction

    function void check_result(ufs_pkg::result_t got);
      ufs_pkg::result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: kind=%0d data=%h ok=%b len=%0d",
                 $time, got.kind, got.data, got.ok, got.length);
        fail_count++;
        return;
      end
      e = expected_q.pop_front();
      if (got.kind !== e.kind) begin
        $display("%0t: kind mismatch: expected %0d, got %0d", $time, e.kind, got.kind);
        fail_count++;
      end
      if (got.data !== e.data) begin
        $display("%0t: data mismatch: expected %h, got %h", $time, e.data, got.data);
        fail_count++;
      end
      if (got.ok !== e.ok) begin
        $display("%0t: frame_ok mismatch: expected %b, got %b", $time, e.ok, got.ok);
        fail_count++;
      end
      if (got.length !== e.length) begin
        $display("%0t: frame_length mismatch: expected %0d, got %0d",
                 $time, e.length, got.length);
        fail_count++;
      end
      if (e.kind == ufs_pkg::KIND_CLOSE) begin
        closes_seen++;
        if (e.ok) good_closes++;
      end else begin
        data_seen++;
      end
    endfunction
  endclass

  logic                               clk_i;
  logic                               rst_ni = 1'b0;
  logic                               in_valid_i = 1'b0;
  logic                               in_ready_o;
  logic                               action_i = 1'b0;
  logic [ufs_pkg::BYTE_W-1:0]         data_byte_i = '0;
  logic [ufs_pkg::PLEN_W-1:0]         payload_length_i = '0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic                               result_kind_o;
  logic [ufs_pkg::BYTE_W-1:0]         data_out_o;
  logic                               frame_ok_o;
  logic [ufs_pkg::COUNT_W-1:0]        frame_length_o;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [ufs_pkg::APB_ADDR_W-1:0]     paddr = '0;
  logic [ufs_pkg::APB_DATA_W-1:0]     pwdata = '0;
  logic [ufs_pkg::APB_DATA_W-1:0]     prdata;
  logic                               pready;

  frame_scoreboard sb = new();
  bit burst_mode = 1'b0;
  bit frame_toggle = 1'b0;
  int beats_sent = 0;
  int results_seen = 0;

  uvc_payload_frame_splitter_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .data_byte_i      (data_byte_i),
    .payload_length_i (payload_length_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .data_out_o       (data_out_o),
    .frame_ok_o       (frame_ok_o),
    .frame_length_o   (frame_length_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Output side: random stall after each beat, plus two long hold-offs that
  // back the block up into its input.
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        sb.check_result(ufs_pkg::result_t'({result_kind_o, data_out_o, frame_ok_o,
                                            frame_length_o}));
        results_seen++;
        stall = burst_mode ? 0 : $urandom_range(0, 12);
        if (results_seen == 200 || results_seen == 700) stall = HOLD_OFF_CYCLES;
      end else if (stall > 0) begin
        stall--;
      end
      out_ready_i <= (stall == 0);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
        idle = 0;
      else
        idle++;
      if (rst_ni && idle >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle);
        $display("uvc_payload_frame_splitter_top regression: fail");
        $finish;
      end
    end
  end

  task automatic apb_write(logic [ufs_pkg::APB_ADDR_W-1:0] addr,
                           logic [ufs_pkg::APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(logic [ufs_pkg::APB_ADDR_W-1:0] addr,
                                logic [ufs_pkg::COUNT_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[ufs_pkg::COUNT_W-1:0] !== want) begin
      $display("%0t: register readback mismatch: expected %0d, got %0d",
               $time, want, prdata[ufs_pkg::COUNT_W-1:0]);
      sb.fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_beat(ufs_pkg::action_e act, logic [ufs_pkg::BYTE_W-1:0] b,
                           logic [ufs_pkg::PLEN_W-1:0] plen);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= act;
    data_byte_i      <= b;
    payload_length_i <= plen;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_beat(act, b, plen);
    beats_sent++;
  endtask

  // Sends n bytes of a payload; later bytes sometimes carry a stray length.
  task automatic send_payload(logic [ufs_pkg::PLEN_W-1:0] plen, int n,
                              logic [ufs_pkg::BYTE_W-1:0] hdr, bit tog);
    logic [ufs_pkg::BYTE_W-1:0] b;
    logic [ufs_pkg::PLEN_W-1:0] pl;
    for (int i = 0; i < n; i++) begin
      b = ufs_pkg::BYTE_W'($urandom_range(0, 255));
      if (i == 0) b = hdr;
      else if (i == 1) b[0] = tog;
      pl = (i > 0 && $urandom_range(0, 15) == 0) ?
           ufs_pkg::PLEN_W'($urandom_range(0, 8191)) : plen;
      send_beat(ufs_pkg::ACT_BYTE, b, pl);
    end
  endtask

  function automatic logic [ufs_pkg::BYTE_W-1:0] pick_header(int len);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return ufs_pkg::BYTE_W'($urandom_range(0, 1));
    if (r == 1 && len < 255) return ufs_pkg::BYTE_W'($urandom_range(len + 1, 255));
    return ufs_pkg::BYTE_W'($urandom_range(2, (len < 255) ? len : 255));
  endfunction

  task automatic run_stream(int budget);
    int stop_at;
    int r;
    int len;
    int h;
    int npl;
    stop_at = beats_sent + budget;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) burst_mode = ~burst_mode;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_beat(ufs_pkg::ACT_FLUSH, ufs_pkg::BYTE_W'($urandom_range(0, 255)),
                  ufs_pkg::PLEN_W'($urandom_range(0, 8191)));
      end else if (r < 9) begin
        send_beat(ufs_pkg::ACT_BYTE, ufs_pkg::BYTE_W'($urandom_range(0, 255)),
                  ufs_pkg::PLEN_W'($urandom_range(0, 1)));
      end else if (r < 15) begin
        // cut-off payload, then flush to realign
        len = $urandom_range(4, 30);
        send_payload(ufs_pkg::PLEN_W'(len), $urandom_range(1, len - 1), pick_header(len),
                     frame_toggle);
        send_beat(ufs_pkg::ACT_FLUSH, ufs_pkg::BYTE_W'($urandom_range(0, 255)),
                  ufs_pkg::PLEN_W'($urandom_range(0, 8191)));
      end else begin
        if ($urandom_range(0, 7) != 0) frame_toggle = ~frame_toggle;
        if (sb.good_size >= 1 && sb.good_size <= 60 && $urandom_range(0, 1) == 1) begin
          // one payload whose data exactly fills a good frame
          h = $urandom_range(2, 12);
          len = h + int'(sb.good_size);
          send_payload(ufs_pkg::PLEN_W'(len), len, ufs_pkg::BYTE_W'(h), frame_toggle);
        end else begin
          npl = $urandom_range(1, 3);
          repeat (npl) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) :
                  $urandom_range(2, 40);
            send_payload(ufs_pkg::PLEN_W'(len), len, pick_header(len), frame_toggle);
          end
        end
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [ufs_pkg::COUNT_W-1:0] size;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_read_check(EXPECTED_ADDR, ufs_pkg::EXPECTED_RESET);

    // short and zero-length payloads are dropped
    send_beat(ufs_pkg::ACT_BYTE, 8'hFF, 13'd1);
    send_beat(ufs_pkg::ACT_BYTE, 8'h00, 13'd0);
    // smallest legal header, first toggle opens the frame
    send_payload(13'd5, 5, 8'd2, 1'b0);
    // header byte below 2 falls back to payload length; toggle change closes
    send_payload(13'd4, 4, 8'd0, 1'b1);
    // header equal to payload length leaves no data
    send_payload(13'd2, 2, 8'd2, 1'b1);
    // header byte past the payload falls back to 12; toggle change on empty frame
    send_payload(13'd13, 13, 8'd255, 1'b0);
    // flush closes the open frame, the second finds nothing
    send_beat(ufs_pkg::ACT_FLUSH, 8'hFF, 13'h1FFF);
    send_beat(ufs_pkg::ACT_FLUSH, 8'h00, 13'h0000);
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: size = '0;
        1: size = ufs_pkg::COUNT_MAX;
        4: size = ufs_pkg::EXPECTED_RESET;
        default: size = ufs_pkg::COUNT_W'($urandom_range(1, 40));
      endcase
      apb_write(EXPECTED_ADDR, {8'($urandom_range(0, 255)), size});
      sb.set_good_size(size);
      apb_read_check(EXPECTED_ADDR, size);
      if (p == 1) begin
        // oversize length on byte 0 clamps; payload cut short and flushed
        burst_mode = 1'b1;
        frame_toggle = ~frame_toggle;
        send_payload(13'h1FFF, 40, ufs_pkg::BYTE_W'($urandom_range(0, 255)),
                     frame_toggle);
        send_beat(ufs_pkg::ACT_FLUSH, 8'h00, 13'h0000);
        burst_mode = 1'b0;
      end
      run_stream(160);
      drain();
    end
    repeat (10) @(posedge clk_i);

    $display("run: %0d input beats, %0d data bytes and %0d frame closes checked",
             beats_sent, sb.data_seen, sb.closes_seen);
    $display("run: %0d closes at expected size over five register settings",
             sb.good_closes);
    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("uvc_payload_frame_splitter_top regression: pass");
    else
      $display("uvc_payload_frame_splitter_top regression: fail");
    $finish;
  end

endmodule

// ===== uvc_payload_frame_splitter_top.f =====
hw/rtl/ufs_pkg.sv
hw/rtl/ufs_apb_regs.sv
hw/rtl/ufs_core.sv
hw/rtl/ufs_out_buf.sv
hw/rtl/uvc_payload_frame_splitter_top.sv
sim/tb.sv
